/* hdl/ttuv_pkg.sv */
// ----------------------------------------------------------------------------
// ttuv_pkg
// Shared widths, codes and the controller-to-datapath command bundle for the
// triangle tangent block.
// ----------------------------------------------------------------------------
package ttuv_pkg;

    localparam int INDEX_W  = 24;
    localparam int COORD_W  = 32;
    localparam int DELTA_W  = 33;
    localparam int PROD_W   = 66;
    localparam int ACC_W    = 67;
    localparam int MAG_W    = 66;
    localparam int NORM_W   = 30;
    localparam int TAN_W    = 16;
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = 32;
    localparam int NUM_W    = 45;
    localparam int QUOT_W   = 17;
    localparam int CNT_W    = 5;
    localparam int STEP_W   = 4;

    localparam logic [QUOT_W-1:0] QUOT_ONE = QUOT_W'(16384);
    localparam logic [CNT_W-1:0]  SQRT_LAST = CNT_W'(31);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(QUOT_W - 1);

    // multiplier operand pair, one per product in the sequence
    typedef enum logic [STEP_W-1:0] {
        MS_U0V1  = 4'd0,
        MS_U1V0  = 4'd1,
        MS_V1E0X = 4'd2,
        MS_V0E1X = 4'd3,
        MS_V1E0Y = 4'd4,
        MS_V0E1Y = 4'd5,
        MS_V1E0Z = 4'd6,
        MS_V0E1Z = 4'd7,
        MS_SQ0   = 4'd8,
        MS_SQ1   = 4'd9,
        MS_SQ2   = 4'd10
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic       load_hold;
        logic       hold_slot;
        logic       load_third;
        logic       make_deltas;
        logic       mul_en;
        mul_sel_t   mul_sel;
        acc_op_t    acc_op;
        logic       store_en;
        logic [1:0] store_sel;
        logic       take_mag;
        logic       norm_en;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic [1:0] lane;
        logic       div_store;
        logic       clear_tan;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic norm_zero;
        logic norm_big;
        logic norm_small;
    } dp_stat_t;

endpackage

/* hdl/ttuv_ctrl.sv */
// ----------------------------------------------------------------------------
// ttuv_ctrl
// Sequencer: corner counting, product schedule, normalize, root and divide
// loops, and the result handshake.
// ----------------------------------------------------------------------------
module ttuv_ctrl
    import ttuv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b000000000001,
        ST_DELTA     = 12'b000000000010,
        ST_MUL       = 12'b000000000100,
        ST_ACC       = 12'b000000001000,
        ST_CHK       = 12'b000000010000,
        ST_NORM      = 12'b000000100000,
        ST_SQRT_INIT = 12'b000001000000,
        ST_SQRT      = 12'b000010000000,
        ST_DIV_INIT  = 12'b000100000000,
        ST_DIV       = 12'b001000000000,
        ST_DIV_STORE = 12'b010000000000,
        ST_EMIT      = 12'b100000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          count_reg, count_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]          lane_reg, lane_next;
    logic                m_valid_reg, m_valid_next;
    logic                accept;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        lane_next    = lane_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.mul_sel  = mul_sel_t'(step_reg);
        cmd.acc_op   = ACC_HOLD;
        cmd.lane     = lane_reg;
        cmd.hold_slot = count_reg[0];
        cmd.store_sel = step_reg[2:1];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (count_reg < 2'd2) begin
                        cmd.load_hold = 1'b1;
                        count_next    = count_reg + 2'd1;
                    end else begin
                        cmd.load_third = 1'b1;
                        count_next     = 2'd0;
                        state_next     = ST_DELTA;
                    end
                end
            end
            ST_DELTA: begin
                cmd.make_deltas = 1'b1;
                step_next       = '0;
                state_next      = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // even cross steps start a difference, odd ones finish it
                if (step_reg >= STEP_W'(MS_SQ0)) begin
                    cmd.acc_op = (step_reg == STEP_W'(MS_SQ0)) ? ACC_LOAD : ACC_ADD;
                end else if (step_reg[0]) begin
                    cmd.acc_op   = ACC_SUB;
                    cmd.store_en = 1'b1;
                end else begin
                    cmd.acc_op = ACC_LOAD;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MS_V0E1Z)) begin
                    state_next = ST_CHK;
                end else if (step_reg == STEP_W'(MS_SQ2)) begin
                    state_next = ST_SQRT_INIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_CHK: begin
                if (stat.det_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.take_mag = 1'b1;
                    state_next   = ST_NORM;
                end
            end
            ST_NORM: begin
                priority if (stat.norm_zero) begin
                    cmd.clear_tan = 1'b1;
                    state_next    = ST_EMIT;
                end else if (stat.norm_big || stat.norm_small) begin
                    cmd.norm_en = 1'b1;
                end else begin
                    step_next  = STEP_W'(MS_SQ0);
                    state_next = ST_MUL;
                end
            end
            ST_SQRT_INIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == SQRT_LAST) begin
                    lane_next  = 2'd0;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE: begin
                cmd.div_store = 1'b1;
                lane_next     = lane_reg + 2'd1;
                state_next    = (lane_reg == 2'd2) ? ST_EMIT : ST_DIV_INIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            cnt_reg     <= '0;
            lane_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            lane_reg    <= lane_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* hdl/ttuv_dpath.sv */
// ----------------------------------------------------------------------------
// ttuv_dpath
// Corner store, deltas, shared multiplier and accumulator, normalizer,
// bit-serial square root, restoring divider and result register.
// ----------------------------------------------------------------------------
module ttuv_dpath
    import ttuv_pkg::*;
(
    input  logic                      aclk,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    input  logic [INDEX_W-1:0]        s_vertex_index,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [COORD_W-1:0] s_pos_z,
    input  logic signed [COORD_W-1:0] s_tex_s,
    input  logic signed [COORD_W-1:0] s_tex_t,
    output logic [INDEX_W-1:0]        m_first_index,
    output logic [INDEX_W-1:0]        m_second_index,
    output logic [INDEX_W-1:0]        m_third_index,
    output logic signed [TAN_W-1:0]   m_tangent_x,
    output logic signed [TAN_W-1:0]   m_tangent_y,
    output logic signed [TAN_W-1:0]   m_tangent_z
);

    logic [INDEX_W-1:0]        idx_reg [3];
    logic signed [COORD_W-1:0] pos_reg [3][3];
    logic signed [COORD_W-1:0] tex_reg [3][2];
    logic signed [DELTA_W-1:0] e0_reg [3];
    logic signed [DELTA_W-1:0] e1_reg [3];
    logic signed [DELTA_W-1:0] u0_reg, v0_reg, u1_reg, v1_reg;
    logic signed [DELTA_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, prod_ext;
    logic signed [ACC_W-1:0]   det_reg;
    logic signed [ACC_W-1:0]   comp_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic                      neg_reg [3];
    logic [MAG_W-1:0]          mag_or;
    logic [SQ_W-1:0]           x_reg, r_reg, bit_reg, trial_root;
    logic [ROOT_W-1:0]         len_reg, len_val, rem_reg, trial_div;
    logic [NUM_W-1:0]          num;
    logic [QUOT_W-1:0]         numlow_reg, q_reg, q_sat;
    logic [TAN_W-1:0]          tan_reg [3];
    logic [NORM_W-1:0]         m_lane;

    assign mag_or          = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign stat.norm_zero  = mag_or == '0;
    assign stat.norm_big   = |mag_or[MAG_W-1:NORM_W];
    assign stat.norm_small = !stat.norm_big && !mag_or[NORM_W-1];
    assign stat.det_zero   = det_reg == '0;

    always_comb begin
        unique case (cmd.mul_sel)
            MS_U0V1:  begin mul_a = u0_reg; mul_b = v1_reg; end
            MS_U1V0:  begin mul_a = u1_reg; mul_b = v0_reg; end
            MS_V1E0X: begin mul_a = v1_reg; mul_b = e0_reg[0]; end
            MS_V0E1X: begin mul_a = v0_reg; mul_b = e1_reg[0]; end
            MS_V1E0Y: begin mul_a = v1_reg; mul_b = e0_reg[1]; end
            MS_V0E1Y: begin mul_a = v0_reg; mul_b = e1_reg[1]; end
            MS_V1E0Z: begin mul_a = v1_reg; mul_b = e0_reg[2]; end
            MS_V0E1Z: begin mul_a = v0_reg; mul_b = e1_reg[2]; end
            MS_SQ0: begin
                mul_a = $signed({3'b000, mag_reg[0][NORM_W-1:0]});
                mul_b = mul_a;
            end
            MS_SQ1: begin
                mul_a = $signed({3'b000, mag_reg[1][NORM_W-1:0]});
                mul_b = mul_a;
            end
            MS_SQ2: begin
                mul_a = $signed({3'b000, mag_reg[2][NORM_W-1:0]});
                mul_b = mul_a;
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);

    always_comb begin
        unique case (cmd.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // root step and divider step
    assign trial_root = r_reg + bit_reg;
    assign len_val    = (r_reg[ROOT_W-1:0] == '0) ? ROOT_W'(1) : r_reg[ROOT_W-1:0];
    assign m_lane     = mag_reg[cmd.lane][NORM_W-1:0];
    assign num        = {1'b0, m_lane, 14'b0} + NUM_W'(len_val >> 1);
    assign trial_div  = {rem_reg[ROOT_W-2:0], numlow_reg[QUOT_W-1]};
    assign q_sat      = (q_reg > QUOT_ONE) ? QUOT_ONE : q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_hold) begin
            idx_reg[cmd.hold_slot]    <= s_vertex_index;
            pos_reg[cmd.hold_slot][0] <= s_pos_x;
            pos_reg[cmd.hold_slot][1] <= s_pos_y;
            pos_reg[cmd.hold_slot][2] <= s_pos_z;
            tex_reg[cmd.hold_slot][0] <= s_tex_s;
            tex_reg[cmd.hold_slot][1] <= s_tex_t;
        end
        if (cmd.load_third) begin
            idx_reg[2]    <= s_vertex_index;
            pos_reg[2][0] <= s_pos_x;
            pos_reg[2][1] <= s_pos_y;
            pos_reg[2][2] <= s_pos_z;
            tex_reg[2][0] <= s_tex_s;
            tex_reg[2][1] <= s_tex_t;
        end
        if (cmd.make_deltas) begin
            for (int k = 0; k < 3; k++) begin
                e0_reg[k] <= DELTA_W'(pos_reg[1][k]) - DELTA_W'(pos_reg[0][k]);
                e1_reg[k] <= DELTA_W'(pos_reg[2][k]) - DELTA_W'(pos_reg[0][k]);
            end
            u0_reg <= DELTA_W'(tex_reg[1][0]) - DELTA_W'(tex_reg[0][0]);
            v0_reg <= DELTA_W'(tex_reg[1][1]) - DELTA_W'(tex_reg[0][1]);
            u1_reg <= DELTA_W'(tex_reg[2][0]) - DELTA_W'(tex_reg[0][0]);
            v1_reg <= DELTA_W'(tex_reg[2][1]) - DELTA_W'(tex_reg[0][1]);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        acc_reg <= acc_next;
        if (cmd.store_en) begin
            if (cmd.store_sel == 2'd0) begin
                det_reg <= acc_next;
            end else begin
                comp_reg[cmd.store_sel - 2'd1] <= acc_next;
            end
        end
        if (cmd.take_mag) begin
            for (int k = 0; k < 3; k++) begin
                neg_reg[k] <= comp_reg[k][ACC_W-1];
                mag_reg[k] <= comp_reg[k][ACC_W-1] ? MAG_W'(-comp_reg[k])
                                                   : MAG_W'(comp_reg[k]);
            end
        end
        if (cmd.norm_en) begin
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= stat.norm_big ? (mag_reg[k] >> 1) : (mag_reg[k] << 1);
            end
        end
        if (cmd.sqrt_init) begin
            x_reg   <= acc_reg[SQ_W-1:0];
            r_reg   <= '0;
            bit_reg <= SQ_W'(1) << 62;
        end
        if (cmd.sqrt_step) begin
            if (x_reg >= trial_root) begin
                x_reg <= x_reg - trial_root;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init) begin
            if (cmd.lane == 2'd0) begin
                len_reg <= len_val;
            end
            rem_reg    <= ROOT_W'(num[NUM_W-1:QUOT_W]);
            numlow_reg <= num[QUOT_W-1:0];
            q_reg      <= '0;
        end
        if (cmd.div_step) begin
            if (trial_div >= len_reg) begin
                rem_reg <= trial_div - len_reg;
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial_div;
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b0};
            end
            numlow_reg <= numlow_reg << 1;
        end
        if (cmd.div_store) begin
            tan_reg[cmd.lane] <= neg_reg[cmd.lane] ? TAN_W'(-q_sat) : TAN_W'(q_sat);
        end
        if (cmd.clear_tan) begin
            for (int k = 0; k < 3; k++) begin
                tan_reg[k] <= '0;
            end
        end
        if (cmd.load_out) begin
            m_first_index  <= idx_reg[0];
            m_second_index <= idx_reg[1];
            m_third_index  <= idx_reg[2];
            m_tangent_x    <= tan_reg[0];
            m_tangent_y    <= tan_reg[1];
            m_tangent_z    <= tan_reg[2];
        end
    end

endmodule

/* hdl/triangle_tangent_from_uv.sv */
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv
// Per-triangle unit tangent from corner positions and texture coordinates.
// ----------------------------------------------------------------------------
//
//  channel  | ports         | word
//  ---------+---------------+-------------------------------------------------
//  input    | s_valid/ready | one triangle corner: index, position, texcoord
//  result   | m_valid/ready | three indices and Q1.14 tangent, per triangle
//
//  Corners one and two are taken in one cycle each. The third corner starts
//  the sequence: the deltas, the determinant and tangent products through
//  the shared multiplier, the check, the normalize shifts, the squares, the
//  root loop and a divide loop for each of the three components, then emit.
//  A zero tangent goes from normalize straight to emit. A flat-UV triangle
//  drops out after the check and gives no result word.
//  Reset (synchronous, aresetn low) clears the corner count and the FSM.
//  A waiting result is held in the output register; input stalls from the
//  third corner until its word is loaded into that register, or until the
//  check drops a flat-UV triangle.
//
module triangle_tangent_from_uv
    import ttuv_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [INDEX_W-1:0]        s_vertex_index,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [COORD_W-1:0] s_pos_z,
    input  logic signed [COORD_W-1:0] s_tex_s,
    input  logic signed [COORD_W-1:0] s_tex_t,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [INDEX_W-1:0]        m_first_index,
    output logic [INDEX_W-1:0]        m_second_index,
    output logic [INDEX_W-1:0]        m_third_index,
    output logic signed [TAN_W-1:0]   m_tangent_x,
    output logic signed [TAN_W-1:0]   m_tangent_y,
    output logic signed [TAN_W-1:0]   m_tangent_z
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: owns both handshakes and the corner count
    ttuv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic and storage, driven by command word only
    ttuv_dpath u_dpath (
        .aclk           (aclk),
        .cmd            (cmd),
        .stat           (stat),
        .s_vertex_index (s_vertex_index),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_tex_s        (s_tex_s),
        .s_tex_t        (s_tex_t),
        .m_first_index  (m_first_index),
        .m_second_index (m_second_index),
        .m_third_index  (m_third_index),
        .m_tangent_x    (m_tangent_x),
        .m_tangent_y    (m_tangent_y),
        .m_tangent_z    (m_tangent_z)
    );

endmodule

/* test/tangent_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tangent_checker
// Watches both channels of triangle_tangent_from_uv, predicts each triangle's
// indices and unit tangent from the accepted corners, and compares results.
// ----------------------------------------------------------------------------
module tangent_checker
    import ttuv_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [INDEX_W-1:0]        s_vertex_index,
    input  logic signed [COORD_W-1:0] s_pos_x,
    input  logic signed [COORD_W-1:0] s_pos_y,
    input  logic signed [COORD_W-1:0] s_pos_z,
    input  logic signed [COORD_W-1:0] s_tex_s,
    input  logic signed [COORD_W-1:0] s_tex_t,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [INDEX_W-1:0]        m_first_index,
    input  logic [INDEX_W-1:0]        m_second_index,
    input  logic [INDEX_W-1:0]        m_third_index,
    input  logic signed [TAN_W-1:0]   m_tangent_x,
    input  logic signed [TAN_W-1:0]   m_tangent_y,
    input  logic signed [TAN_W-1:0]   m_tangent_z,
    output int                        fail_count,
    output int                        tangents_pending,
    output int                        tangents_checked,
    output int                        flat_triangles
);

    typedef struct packed {
        logic [INDEX_W-1:0]      idx0;
        logic [INDEX_W-1:0]      idx1;
        logic [INDEX_W-1:0]      idx2;
        logic signed [TAN_W-1:0] tx;
        logic signed [TAN_W-1:0] ty;
        logic signed [TAN_W-1:0] tz;
    } tangent_word_t;

    tangent_word_t  tangent_q[$];
    int             corners_held;
    logic [INDEX_W-1:0]      held_idx [2];
    logic signed [COORD_W-1:0] held_pos [2][3];
    logic signed [COORD_W-1:0] held_uv  [2][2];

    assign tangents_pending = tangent_q.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Exact edge/delta arithmetic, then scale to 30 bits and normalize.
    // Returns 0 when the UV determinant is zero (no word produced).
    function automatic bit predict_tangent(input logic signed [COORD_W-1:0] p2 [3],
                                           input logic signed [COORD_W-1:0] uv2 [2],
                                           output logic signed [TAN_W-1:0] t [3]);
        logic signed [127:0] e0 [3];
        logic signed [127:0] e1 [3];
        logic signed [127:0] u0, v0, u1, v1, det, c;
        logic [127:0]        mag [3];
        logic [63:0]         m [3];
        logic [63:0]         sum, len, q;
        bit                  neg [3];
        int                  maxlen, k, b;
        for (k = 0; k < 3; k++) begin
            e0[k] = 128'(held_pos[1][k]) - 128'(held_pos[0][k]);
            e1[k] = 128'(p2[k]) - 128'(held_pos[0][k]);
        end
        u0 = 128'(held_uv[1][0]) - 128'(held_uv[0][0]);
        v0 = 128'(held_uv[1][1]) - 128'(held_uv[0][1]);
        u1 = 128'(uv2[0]) - 128'(held_uv[0][0]);
        v1 = 128'(uv2[1]) - 128'(held_uv[0][1]);
        det = u0 * v1 - u1 * v0;
        if (det == 0) return 0;
        maxlen = 0;
        for (k = 0; k < 3; k++) begin
            c = v1 * e0[k] - v0 * e1[k];
            neg[k] = c[127];
            mag[k] = neg[k] ? -c : c;
            for (b = 127; b >= 0; b--) begin
                if (mag[k][b]) begin
                    if (b + 1 > maxlen) maxlen = b + 1;
                    break;
                end
            end
        end
        for (k = 0; k < 3; k++) t[k] = '0;
        if (maxlen == 0) return 1;
        for (k = 0; k < 3; k++) begin
            if (maxlen > NORM_W) m[k] = 64'(mag[k] >> (maxlen - NORM_W));
            else                 m[k] = 64'(mag[k] << (NORM_W - maxlen));
            m[k] = m[k] & ((64'd1 << NORM_W) - 1);
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        if (len == 0) len = 1;
        for (k = 0; k < 3; k++) begin
            q = (m[k] * 64'd16384 + len / 2) / len;
            if (q > 64'd16384) q = 64'd16384;
            t[k] = neg[k] ? -TAN_W'(q) : TAN_W'(q);
        end
        return 1;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count       = 0;
        tangents_checked = 0;
        flat_triangles   = 0;
        corners_held     = 0;
    end

    always @(posedge aclk) begin
        logic signed [COORD_W-1:0] p2 [3];
        logic signed [COORD_W-1:0] uv2 [2];
        logic signed [TAN_W-1:0]   t [3];
        tangent_word_t             w;
        if (!aresetn) begin
            corners_held = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (corners_held < 2) begin
                    held_idx[corners_held]    = s_vertex_index;
                    held_pos[corners_held][0] = s_pos_x;
                    held_pos[corners_held][1] = s_pos_y;
                    held_pos[corners_held][2] = s_pos_z;
                    held_uv[corners_held][0]  = s_tex_s;
                    held_uv[corners_held][1]  = s_tex_t;
                    corners_held++;
                end else begin
                    corners_held = 0;
                    p2[0] = s_pos_x; p2[1] = s_pos_y; p2[2] = s_pos_z;
                    uv2[0] = s_tex_s; uv2[1] = s_tex_t;
                    if (predict_tangent(p2, uv2, t)) begin
                        w = '{held_idx[0], held_idx[1], s_vertex_index, t[0], t[1], t[2]};
                        tangent_q = {tangent_q, w};
                    end else begin
                        flat_triangles++;
                    end
                end
            end
            if (m_valid && m_ready) begin
                if (tangent_q.size() == 0) begin
                    report("result words", tangents_checked + 1, tangents_checked);
                end else begin
                    w = tangent_q.pop_front();
                    tangents_checked++;
                    if (m_first_index != w.idx0)  report("first_index", m_first_index, w.idx0);
                    if (m_second_index != w.idx1) report("second_index", m_second_index, w.idx1);
                    if (m_third_index != w.idx2)  report("third_index", m_third_index, w.idx2);
                    if (m_tangent_x != w.tx)      report("tangent_x", m_tangent_x, w.tx);
                    if (m_tangent_y != w.ty)      report("tangent_y", m_tangent_y, w.ty);
                    if (m_tangent_z != w.tz)      report("tangent_z", m_tangent_z, w.tz);
                end
            end
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives triangle corners into triangle_tangent_from_uv under several idle and
// stall mixes; the checker beside the block predicts and compares each word.
// ----------------------------------------------------------------------------
module tb;
    import ttuv_pkg::*;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [INDEX_W-1:0]        s_vertex_index;
    logic signed [COORD_W-1:0] s_pos_x, s_pos_y, s_pos_z, s_tex_s, s_tex_t;
    logic                      m_valid;
    logic                      m_ready;
    logic [INDEX_W-1:0]        m_first_index, m_second_index, m_third_index;
    logic signed [TAN_W-1:0]   m_tangent_x, m_tangent_y, m_tangent_z;

    int fail_count, tangents_pending, tangents_checked, flat_triangles;

    // idle percentages per side; hold_request starts one long receiver stall
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_request;
    int hold_left;
    int corners_sent;

    typedef struct {
        logic [INDEX_W-1:0]        idx;
        logic signed [COORD_W-1:0] p [3];
        logic signed [COORD_W-1:0] uv [2];
    } corner_t;

    // triangle shapes for the random part
    typedef enum int {
        SHAPE_WIDE,     // full-range random values
        SHAPE_MESH,     // modest coordinates like a real mesh
        SHAPE_FLAT_UV,  // repeated texcoord: zero determinant
        SHAPE_POINT     // all corners at one position: zero tangent
    } tri_shape_t;

    triangle_tangent_from_uv u_top (.*);

    tangent_checker u_check (.*);

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: stall at random, or hold off for a counted stretch on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_request > 0) begin
            hold_left    <= hold_request;
            hold_request = 0;
            m_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offer one corner, with a random gap first; hold until accepted.
    task automatic send_corner(input corner_t c);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid        <= 1'b1;
        s_vertex_index <= c.idx;
        s_pos_x        <= c.p[0];
        s_pos_y        <= c.p[1];
        s_pos_z        <= c.p[2];
        s_tex_s        <= c.uv[0];
        s_tex_t        <= c.uv[1];
        do @(posedge aclk); while (!s_ready);
        corners_sent++;
    endtask

    task automatic send_triangle(input corner_t c0, input corner_t c1, input corner_t c2);
        send_corner(c0);
        send_corner(c1);
        send_corner(c2);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord(input tri_shape_t shape);
        if (shape == SHAPE_WIDE) return $urandom;
        return (COORD_W'($urandom_range(65535)) - 32'sd32768) <<< $urandom_range(12);
    endfunction

    task automatic random_triangle(input tri_shape_t shape);
        corner_t c [3];
        int      i, k;
        for (i = 0; i < 3; i++) begin
            c[i].idx = $urandom;
            for (k = 0; k < 3; k++) c[i].p[k] = pick_coord(shape);
            for (k = 0; k < 2; k++) c[i].uv[k] = pick_coord(shape);
        end
        if (shape == SHAPE_FLAT_UV) begin
            // repeat one texcoord: one UV edge collapses, so the determinant is zero
            k = $urandom_range(2);
            if (k == 0)      c[1].uv = c[0].uv;
            else if (k == 1) c[2].uv = c[0].uv;
            else             c[2].uv = c[1].uv;
        end
        if (shape == SHAPE_POINT) begin
            c[1].p = c[0].p;
            c[2].p = c[0].p;
        end
        send_triangle(c[0], c[1], c[2]);
    endtask

    function automatic corner_t mk(input logic [INDEX_W-1:0] idx,
                                   input int x, input int y, input int z,
                                   input int s, input int t);
        corner_t c;
        c.idx = idx;
        c.p[0] = x; c.p[1] = y; c.p[2] = z;
        c.uv[0] = s; c.uv[1] = t;
        return c;
    endfunction

    // Random batch under the current idle mix, shapes weighted toward meshes.
    task automatic random_batch(input int triangles);
        int n, r;
        for (n = 0; n < triangles; n++) begin
            r = $urandom_range(99);
            if (r < 50)      random_triangle(SHAPE_MESH);
            else if (r < 80) random_triangle(SHAPE_WIDE);
            else if (r < 92) random_triangle(SHAPE_FLAT_UV);
            else             random_triangle(SHAPE_POINT);
        end
    endtask

    // Let the block drain: all words in, then cover a flat triangle in flight.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tangents_pending != 0);
        repeat (300) @(posedge aclk);
    endtask

    localparam int ONE  = 32'sh0001_0000;
    localparam int MAXC = 32'sh7FFF_FFFF;
    localparam int MINC = 32'sh8000_0000;

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_vertex_index     = '0;
        s_pos_x            = '0;
        s_pos_y            = '0;
        s_pos_z            = '0;
        s_tex_s            = '0;
        s_tex_t            = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 0;
        corners_sent       = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: unit right triangle, extremes, flat UV, point triangle.
        send_triangle(mk(0, 0, 0, 0, 0, 0), mk(1, ONE, 0, 0, ONE, 0),
                      mk(2, 0, ONE, 0, 0, ONE));
        send_triangle(mk(24'hFFFFFF, MINC, MINC, MINC, MINC, MINC),
                      mk(24'hAAAAAA, MAXC, MAXC, MAXC, MAXC, MINC),
                      mk(24'h555555, MINC, MAXC, MINC, MINC, MAXC));
        send_triangle(mk(7, MAXC, MINC, MAXC, MAXC, MAXC),
                      mk(8, MINC, MAXC, MINC, MINC, MINC),
                      mk(9, 0, 0, MAXC, MAXC, MINC));
        send_triangle(mk(10, 1, 2, 3, ONE, ONE), mk(11, 4, 5, 6, ONE, ONE),
                      mk(12, 7, 8, 9, 5, 5));
        send_triangle(mk(13, ONE, ONE, ONE, 0, 0), mk(14, ONE, ONE, ONE, ONE, 0),
                      mk(15, ONE, ONE, ONE, 0, ONE));
        send_triangle(mk(16, 0, 0, 0, 0, 0), mk(17, 1, 0, 0, 1, 0),
                      mk(18, 0, 1, 0, 0, 1));
        send_triangle(mk(19, 0, 0, 0, 0, 0), mk(20, 0, 0, 0, MAXC, 3),
                      mk(21, 0, 0, -1, MINC, -1));
        drain();

        // Phase: no idling on either side.
        random_batch(45);
        drain();

        // Phase: sender idle most of the time.
        sender_idle_pct = 86;
        random_batch(40);
        drain();

        // Phase: receiver stalling most of the time.
        sender_idle_pct    = 0;
        receiver_stall_pct = 86;
        random_batch(40);
        drain();

        // Phase: both sides idle a third of the time.
        sender_idle_pct    = 33;
        receiver_stall_pct = 33;
        random_batch(40);

        // Long receiver hold-off while the sender keeps offering corners.
        sender_idle_pct = 0;
        hold_request    = 1500;
        random_batch(20);
        drain();

        $display("Covered %0d corners: %0d tangent words checked, %0d flat-UV triangles",
                 corners_sent, tangents_checked, flat_triangles);
        $display("Idle mixes: none, sender, receiver, both; plus one long receiver hold-off");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run-time limit, far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("Timeout waiting on the block");
        $display("Some tests failed");
        $finish;
    end

endmodule
